// ----- sv/e2q_pkg.sv -----
// Shared constants, types and helpers for the Euler-to-quaternion converter.
package e2q_pkg;

    // Angle and arithmetic widths
    localparam int ANGLE_WIDTH = 16;
    localparam int VW = 31;             // Q30 fraction, holds 1.0
    localparam int PW = 32;             // polynomial accumulator
    localparam int SW = 17;             // unsigned half-angle sine, 0..32768
    localparam int QW = 16;             // output Q1.15
    localparam int NLANE = 6;           // sin and cos of three angles
    localparam int NSTEP = 4;           // Horner steps after the seed

    localparam logic [VW-1:0] Q30_ONE = VW'(32'h4000_0000);

    // Taylor coefficients of sin(v*pi/2), Q30
    localparam logic [PW-1:0] C1 = 32'd1686629713;
    localparam logic [PW-1:0] C3 = 32'd693598668;
    localparam logic [PW-1:0] C5 = 32'd85569306;
    localparam logic [PW-1:0] C7 = 32'd5026994;
    localparam logic [PW-1:0] C9 = 32'd172272;

    // One lane of the polynomial chain
    typedef struct packed {
        logic [VW-1:0] v;
        logic [VW-1:0] v2;
        logic [PW-1:0] p;
    } lane_t;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_YXZ = 3'd1,
        ORD_ZXY = 3'd2,
        ORD_ZYX = 3'd3,
        ORD_YZX = 3'd4,
        ORD_XZY = 3'd5
    } order_t;

    // Coefficient used by each Horner step, outermost first
    function automatic logic [PW-1:0] step_coef(input int step);
        logic [PW-1:0] c;
        unique case (step)
            0:       c = C7;
            1:       c = C5;
            2:       c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

    // Bit i set: second product of component i (x,y,z,w) is subtracted
    function automatic logic [3:0] order_neg(input logic [2:0] order);
        logic [3:0] n;
        unique case (order)
            ORD_XYZ: n = 4'b1010;
            ORD_YXZ: n = 4'b0110;
            ORD_ZXY: n = 4'b1001;
            ORD_ZYX: n = 4'b0101;
            ORD_YZX: n = 4'b1100;
            ORD_XZY: n = 4'b0011;
            default: n = 4'b1010;   // unused codes behave as XYZ
        endcase
        return n;
    endfunction

endpackage

// ----- sv/e2q_if.sv -----
// Valid/ready channel interfaces for the converter's input and result words.
interface e2q_in_if;
    import e2q_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;
    logic [2:0]                    rotation_order;

    modport source (output valid, angle_x, angle_y, angle_z, rotation_order, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, rotation_order, output ready);
endinterface

interface e2q_out_if;
    import e2q_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- sv/e2q_horner_cell.sv -----
// One Horner step of the sine polynomial for all six lanes: p = c - v2*p.
module e2q_horner_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  logic [e2q_pkg::PW-1:0]   coef,
    input  e2q_pkg::lane_t           lane_in  [e2q_pkg::NLANE],
    output logic                     valid_out,
    output e2q_pkg::lane_t           lane_out [e2q_pkg::NLANE]
);
    import e2q_pkg::*;

    logic   valid_reg;
    lane_t  lane_reg  [NLANE];
    lane_t  lane_next [NLANE];
    logic [VW+PW-1:0] prod [NLANE];

    // multiply-subtract per lane
    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            prod[i]         = (VW+PW)'(lane_in[i].v2) * (VW+PW)'(lane_in[i].p);
            lane_next[i].v  = lane_in[i].v;
            lane_next[i].v2 = lane_in[i].v2;
            lane_next[i].p  = coef - prod[i][PW+29:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

// ----- sv/euler_to_quaternion.sv -----
// Top level: pipelined Euler angles to unit quaternion converter.
// Accepts one word per clock while the output is not stalled and returns one quaternion
// per word, in order, through the chain:
// input register, squaring, four Horner cells of the half-angle sine polynomial, sine
// rounding, pair products, triple products, and the rounding/saturating output register.
// A stall at the output holds the whole chain; ready is high whenever the output
// register is empty or being taken.
module euler_to_quaternion (
    input  logic clk,
    input  logic rst_n,
    e2q_in_if.sink    din,
    e2q_out_if.source dout
);
    import e2q_pkg::*;

    logic adv;
    assign adv      = !dout.valid || dout.ready;
    assign din.ready = adv;

    // stage 0: magnitude to Q30 fraction
    logic            vld0_reg;
    logic [2:0]      neg0_reg;
    logic [2:0]      ord0_reg;
    logic [VW-1:0]   v0_reg [NLANE];
    logic [VW-1:0]   v0_next [NLANE];
    logic [2:0]      neg0_next;
    logic [ANGLE_WIDTH-1:0] ang [3];
    logic [ANGLE_WIDTH:0]   mag [3];
    logic [VW-1:0]          vf  [3];

    always_comb
    begin
        ang[0] = din.angle_x;
        ang[1] = din.angle_y;
        ang[2] = din.angle_z;
        for (int k = 0; k < 3; k++)
        begin
            neg0_next[k] = ang[k][ANGLE_WIDTH-1];
            mag[k] = neg0_next[k] ? ((ANGLE_WIDTH+1)'(1) << ANGLE_WIDTH) - {1'b0, ang[k]}
                                  : {1'b0, ang[k]};
            vf[k]  = VW'(mag[k]) << (VW - ANGLE_WIDTH);
            if (vf[k] > Q30_ONE)
                vf[k] = Q30_ONE;
            v0_next[2*k]   = vf[k];
            v0_next[2*k+1] = Q30_ONE - vf[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (adv)
            vld0_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_reg   <= v0_next;
            neg0_reg <= neg0_next;
            ord0_reg <= din.rotation_order;
        end
    end

    // stage 1: square and seed the polynomial
    logic          vld1_reg;
    lane_t         lane1_reg [NLANE];
    lane_t         lane1_next [NLANE];
    logic [2*VW-1:0] sq [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            sq[i]            = (2*VW)'(v0_reg[i]) * (2*VW)'(v0_reg[i]);
            lane1_next[i].v  = v0_reg[i];
            lane1_next[i].v2 = sq[i][VW+29:30];
            lane1_next[i].p  = C9;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (adv)
            vld1_reg <= vld0_reg;
    end

    // side data travels with the chain
    logic [2:0] neg_reg [NSTEP+2];
    logic [2:0] ord_reg [NSTEP+2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane1_reg  <= lane1_next;
            neg_reg[0] <= neg0_reg;
            ord_reg[0] <= ord0_reg;
            for (int s = 1; s < NSTEP+2; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                ord_reg[s] <= ord_reg[s-1];
            end
        end
    end

    // stages 2..5: row of Horner cells
    logic  cvld  [NSTEP+1];
    lane_t clane [NSTEP+1][NLANE];

    assign cvld[0]  = vld1_reg;
    assign clane[0] = lane1_reg;

    for (genvar s = 0; s < NSTEP; s++)
    begin : g_cell
        e2q_horner_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (cvld[s]),
            .coef      (step_coef(s)),
            .lane_in   (clane[s]),
            .valid_out (cvld[s+1]),
            .lane_out  (clane[s+1])
        );
    end

    // stage 6: final multiply by v, clamp, round to Q15
    logic          vld6_reg;
    logic [SW-1:0] sv_reg  [NLANE];
    logic [SW-1:0] sv_next [NLANE];
    logic [VW+PW-1:0] fp [NLANE];
    logic [32:0]      ft [NLANE];
    logic [31:0]      fr [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            fp[i] = (VW+PW)'(clane[NSTEP][i].v) * (VW+PW)'(clane[NSTEP][i].p);
            ft[i] = fp[i][VW+PW-1:30];
            if (ft[i] > 33'(Q30_ONE))
                ft[i] = 33'(Q30_ONE);
            fr[i] = ft[i][31:0] + 32'd16384;
            sv_next[i] = fr[i][31:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld6_reg <= 1'b0;
        else if (adv)
            vld6_reg <= cvld[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sv_reg <= sv_next;
    end

    // stage 7: signed sine/cosine and pair products
    logic signed [SW:0]     sc [NLANE];
    logic                   vld7_reg;
    logic signed [2*SW+1:0] sxcy_reg, cxsy_reg, cxcy_reg, sxsy_reg;
    logic signed [SW:0]     sz_reg, cz_reg;
    logic [2:0]             ord7_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sc[2*k]   = neg_reg[NSTEP+1][k] ? -$signed({1'b0, sv_reg[2*k]})
                                            :  $signed({1'b0, sv_reg[2*k]});
            sc[2*k+1] = $signed({1'b0, sv_reg[2*k+1]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld7_reg <= 1'b0;
        else if (adv)
            vld7_reg <= vld6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sxcy_reg <= sc[0] * sc[3];
            cxsy_reg <= sc[1] * sc[2];
            cxcy_reg <= sc[1] * sc[3];
            sxsy_reg <= sc[0] * sc[2];
            sz_reg   <= sc[4];
            cz_reg   <= sc[5];
            ord7_reg <= ord_reg[NSTEP+1];
        end
    end

    // stage 8: triple products
    localparam int TW = 48;
    logic                  vld8_reg;
    logic signed [TW-1:0]  ta_reg [4];
    logic signed [TW-1:0]  tb_reg [4];
    logic [3:0]            neg8_reg;
    logic signed [3*SW+2:0] ta [4];
    logic signed [3*SW+2:0] tb [4];

    always_comb
    begin
        ta[0] = sxcy_reg * cz_reg;  tb[0] = cxsy_reg * sz_reg;
        ta[1] = cxsy_reg * cz_reg;  tb[1] = sxcy_reg * sz_reg;
        ta[2] = cxcy_reg * sz_reg;  tb[2] = sxsy_reg * cz_reg;
        ta[3] = cxcy_reg * cz_reg;  tb[3] = sxsy_reg * sz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld8_reg <= 1'b0;
        else if (adv)
            vld8_reg <= vld7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ta_reg[j] <= ta[j][TW-1:0];
                tb_reg[j] <= tb[j][TW-1:0];
            end
            neg8_reg <= order_neg(ord7_reg);
        end
    end

    // stage 9: sum, round half up, saturate
    logic                 vld9_reg;
    logic signed [QW-1:0] q_reg  [4];
    logic signed [QW-1:0] q_next [4];
    logic signed [TW:0]   qs  [4];
    logic signed [TW:0]   qr  [4];
    logic signed [TW-30:0] qt [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            qs[j] = neg8_reg[j] ? (TW+1)'(ta_reg[j]) - (TW+1)'(tb_reg[j])
                                : (TW+1)'(ta_reg[j]) + (TW+1)'(tb_reg[j]);
            qr[j] = qs[j] + (TW+1)'(1 << 29);
            qt[j] = qr[j][TW:30];
            if (qt[j] > (TW-29)'(32767))
                q_next[j] = 16'sh7fff;
            else if (qt[j] < -(TW-29)'(32768))
                q_next[j] = -16'sh8000;
            else
                q_next[j] = qt[j][QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld9_reg <= 1'b0;
        else if (adv)
            vld9_reg <= vld8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            q_reg <= q_next;
    end

    assign dout.valid  = vld9_reg;
    assign dout.quat_x = q_reg[0];
    assign dout.quat_y = q_reg[1];
    assign dout.quat_z = q_reg[2];
    assign dout.quat_w = q_reg[3];

`ifndef SYNTH
    // input is taken exactly when the chain moves
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        din.ready == (!dout.valid || dout.ready))
        else $error("ready does not follow output stall");

    // rounded half-angle sine never exceeds one
    a_sine_max: assert property (@(posedge clk) disable iff (!rst_n)
        vld6_reg |-> (sv_reg[0] <= 17'd32768 && sv_reg[1] <= 17'd32768 &&
                      sv_reg[2] <= 17'd32768 && sv_reg[3] <= 17'd32768 &&
                      sv_reg[4] <= 17'd32768 && sv_reg[5] <= 17'd32768))
        else $error("half-angle sine out of range");

    // a stalled chain keeps its occupancy at stages 1 and 8
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (vld8_reg == $past(vld8_reg) && vld1_reg == $past(vld1_reg)))
        else $error("pipeline moved during a stall");
`endif

endmodule

// ----- verif/e2q_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench package: orientation and quaternion word types for the converter checks.
package e2q_tb_pkg;
    import e2q_pkg::*;

    // One quaternion result word
    typedef struct packed {
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [QW-1:0] qw;
    } quat_t;

    // One orientation word
    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] ax;
        logic signed [ANGLE_WIDTH-1:0] ay;
        logic signed [ANGLE_WIDTH-1:0] az;
        logic [2:0]                    order;
    } euler_t;
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Euler-to-quaternion converter.
module testbench;
    import e2q_pkg::*;
    import e2q_tb_pkg::*;

    logic clk;
    logic rst_n;

    e2q_in_if  din();
    e2q_out_if dout();

    euler_to_quaternion dut (.clk(clk), .rst_n(rst_n), .din(din), .dout(dout));

    euler_t pending_words[$];
    quat_t  expected_quats[$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    // sin(v*pi/2), v in Q30, result in 2^-15 units
    function automatic longint quarter_sin(longint unsigned v);
        longint unsigned v2, p;
        v2 = (v * v) >> 30;
        p = 64'd172272;
        p = 64'd5026994 - ((v2 * p) >> 30);
        p = 64'd85569306 - ((v2 * p) >> 30);
        p = 64'd693598668 - ((v2 * p) >> 30);
        p = 64'd1686629713 - ((v2 * p) >> 30);
        p = (v * p) >> 30;
        if (p > 64'h4000_0000)
            p = 64'h4000_0000;
        return longint'((p + 64'd16384) >> 15);
    endfunction

    // Half-angle sine and cosine of a binary angle
    function automatic void half_sin_cos(input logic [15:0] a, output longint s,
                                         output longint c);
        longint unsigned m, v;
        m = a[15] ? (64'd65536 - a) : a;
        v = m << 15;
        if (v > 64'h4000_0000)
            v = 64'h4000_0000;
        s = a[15] ? -quarter_sin(v) : quarter_sin(v);
        c = quarter_sin(64'h4000_0000 - v);
    endfunction

    // Round Q45 half up to Q15 and saturate
    function automatic logic signed [15:0] round_q15(longint q45);
        longint r;
        r = (q45 + (longint'(1) << 29)) >>> 30;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic quat_t predict_quat(euler_t e);
        longint sx, cx, sy, cy, sz, cz;
        logic [3:0] neg;
        longint sg[4];
        quat_t q;
        half_sin_cos(e.ax, sx, cx);
        half_sin_cos(e.ay, sy, cy);
        half_sin_cos(e.az, sz, cz);
        case (e.order)
            ORD_YXZ: neg = 4'b0110;
            ORD_ZXY: neg = 4'b1001;
            ORD_ZYX: neg = 4'b0101;
            ORD_YZX: neg = 4'b1100;
            ORD_XZY: neg = 4'b0011;
            default: neg = 4'b1010;
        endcase
        // bit i of neg belongs to component i (x, y, z, w)
        for (int i = 0; i < 4; i++)
            sg[i] = neg[i] ? -1 : 1;
        q.qx = round_q15(sx * cy * cz + sg[0] * (cx * sy * sz));
        q.qy = round_q15(cx * sy * cz + sg[1] * (sx * cy * sz));
        q.qz = round_q15(cx * cy * sz + sg[2] * (sx * sy * cz));
        q.qw = round_q15(cx * cy * cz + sg[3] * (sx * sy * sz));
        return q;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Driver: one word per accepted handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din.valid <= 0;
        end
        else if (!din.valid || din.ready)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                euler_t e;
                e = pending_words.pop_front();
                din.angle_x <= e.ax;
                din.angle_y <= e.ay;
                din.angle_z <= e.az;
                din.rotation_order <= e.order;
                expected_quats.push_back(predict_quat(e));
                din.valid <= 1;
            end
            else
                din.valid <= 0;
        end
    end

    // Monitor: check each taken result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout.valid && dout.ready)
            begin
                quat_t q;
                if (expected_quats.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    q = expected_quats.pop_front();
                    if (dout.quat_x !== q.qx)
                        report_mismatch($sformatf("x got %0d want %0d", dout.quat_x, q.qx));
                    if (dout.quat_y !== q.qy)
                        report_mismatch($sformatf("y got %0d want %0d", dout.quat_y, q.qy));
                    if (dout.quat_z !== q.qz)
                        report_mismatch($sformatf("z got %0d want %0d", dout.quat_z, q.qz));
                    if (dout.quat_w !== q.qw)
                        report_mismatch($sformatf("w got %0d want %0d", dout.quat_w, q.qw));
                end
            end
            dout.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic euler_t rand_word();
        euler_t e;
        e.ax = 16'($urandom);
        e.ay = 16'($urandom);
        e.az = 16'($urandom);
        e.order = 3'($urandom_range(7));
        return e;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || din.valid || expected_quats.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus phases
    initial
    begin
        logic signed [15:0] edge_angles[6];
        euler_t e;
        edge_angles = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh4000, -16'sh0001, 16'sh0001};
        din.valid = 0;
        din.angle_x = 0;
        din.angle_y = 0;
        din.angle_z = 0;
        din.rotation_order = 0;
        dout.ready = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // Directed: zero rotation, extreme angles, every order incl. unused codes
        for (int o = 0; o < 8; o++)
        begin
            e.ax = edge_angles[o % 6];
            e.ay = edge_angles[(o + 2) % 6];
            e.az = edge_angles[(o + 4) % 6];
            e.order = o[2:0];
            pending_words.push_back(e);
        end
        for (int i = 0; i < 6; i++)
        begin
            e.ax = edge_angles[i];
            e.ay = edge_angles[i];
            e.az = edge_angles[i];
            e.order = i[2:0];
            pending_words.push_back(e);
        end
        wait_drained();

        // Pause until idle, then random words under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 79) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 79) : 0;
            for (int i = 0; i < 350; i++)
                pending_words.push_back(rand_word());
            wait_drained();
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[euler_to_quaternion] OK");
        else
            $display("[euler_to_quaternion] ERROR");
        $finish;
    end

    // Timeout
    initial
    begin
        #2ms;
        $display("[euler_to_quaternion] ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
sv/e2q_pkg.sv
sv/e2q_if.sv
sv/e2q_horner_cell.sv
sv/euler_to_quaternion.sv
verif/e2q_tb_if.sv
verif/testbench.sv
